@@ src/rotenc_pkg.sv @@
// Shared types and constants for the rotary encoder event qualifier.
// No dependencies; every other file refers to it by scoped names.
package rotenc_pkg;

    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEEP     = 1'b1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] BEEP_RESET     = 16'd50;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CW     = 2'd1,
        EV_CCW    = 2'd2,
        EV_BUTTON = 2'd3
    } event_code_t;

    typedef struct packed {
        logic               clk_level;
        logic               dir_level;
        logic               switch_level;
        logic [STAMP_W-1:0] now_ms;
        logic               take_event;
    } sample_t;

    typedef struct packed {
        event_code_t event_code;
        logic        event_waiting;
        logic        buzzer_on;
    } result_t;

    // Qualifier to beep timer: an event was accepted in this item
    typedef struct packed {
        logic               hit;
        logic [STAMP_W-1:0] now_ms;
    } hit_t;

endpackage

@@ src/rotenc_if.sv @@
// Valid/ready channel interfaces for encoder samples and event reports.
// Depends on rotenc_pkg for the timestamp width.
interface rotenc_sample_if;
    logic                            valid;
    logic                            ready;
    logic                            clk_level;
    logic                            dir_level;
    logic                            switch_level;
    logic [rotenc_pkg::STAMP_W-1:0]  now_ms;
    logic                            take_event;

    modport source (output valid, clk_level, dir_level, switch_level, now_ms, take_event,
                    input ready);
    modport sink (input valid, clk_level, dir_level, switch_level, now_ms, take_event,
                  output ready);
endinterface

interface rotenc_report_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;
    logic       event_waiting;
    logic       buzzer_on;

    modport source (output valid, event_code, event_waiting, buzzer_on, input ready);
    modport sink (input valid, event_code, event_waiting, buzzer_on, output ready);
endinterface

@@ src/rotenc_qualify.sv @@
// Edge detection, debounce and pending event for the encoder and push switch.
// Depends on rotenc_pkg.
module rotenc_qualify
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  rotenc_pkg::sample_t            smp,
    input  logic [rotenc_pkg::CFG_W-1:0]   debounce_ms,
    output rotenc_pkg::hit_t               hit,
    output rotenc_pkg::event_code_t        taken,
    output logic                           waiting
);

    logic                               prev_clk_reg;
    logic                               prev_switch_reg;
    logic [rotenc_pkg::STAMP_W-1:0]     rotate_stamp_reg;
    logic [rotenc_pkg::STAMP_W-1:0]     press_stamp_reg;
    rotenc_pkg::event_code_t            pending_reg;

    rotenc_pkg::event_code_t            pending_next;
    rotenc_pkg::event_code_t            code_mid;
    logic [rotenc_pkg::STAMP_W-1:0]     rot_elapsed;
    logic [rotenc_pkg::STAMP_W-1:0]     press_elapsed;
    logic [rotenc_pkg::STAMP_W-1:0]     limit;
    logic                               rot_ok;
    logic                               press_ok;

    // Wrap-around elapsed times
    assign rot_elapsed   = smp.now_ms - rotate_stamp_reg;
    assign press_elapsed = smp.now_ms - press_stamp_reg;
    assign limit         = rotenc_pkg::STAMP_W'(debounce_ms);

    assign rot_ok   = prev_clk_reg & ~smp.clk_level & (rot_elapsed > limit);
    assign press_ok = prev_switch_reg & ~smp.switch_level & (press_elapsed > limit);

    always_comb
    begin
        code_mid = pending_reg;
        if (rot_ok)
        begin
            code_mid = smp.dir_level ? rotenc_pkg::EV_CW : rotenc_pkg::EV_CCW;
        end
        // button overrides a rotation in the same item
        if (press_ok)
        begin
            code_mid = rotenc_pkg::EV_BUTTON;
        end
        if (smp.take_event)
        begin
            taken        = code_mid;
            pending_next = rotenc_pkg::EV_NONE;
        end
        else
        begin
            taken        = rotenc_pkg::EV_NONE;
            pending_next = code_mid;
        end
    end

    assign waiting    = (pending_next != rotenc_pkg::EV_NONE);
    assign hit.hit    = rot_ok | press_ok;
    assign hit.now_ms = smp.now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg     <= 1'b1;
            prev_switch_reg  <= 1'b1;
            rotate_stamp_reg <= '0;
            press_stamp_reg  <= '0;
            pending_reg      <= rotenc_pkg::EV_NONE;
        end
        else if (step)
        begin
            prev_clk_reg    <= smp.clk_level;
            prev_switch_reg <= smp.switch_level;
            pending_reg     <= pending_next;
            if (rot_ok)
            begin
                rotate_stamp_reg <= smp.now_ms;
            end
            if (press_ok)
            begin
                press_stamp_reg <= smp.now_ms;
            end
        end
    end

endmodule

@@ src/rotenc_beep.sv @@
// Buzzer timer: restarts on each accepted event, ends once beep_ms has elapsed.
// Depends on rotenc_pkg.
module rotenc_beep
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  rotenc_pkg::hit_t               hit,
    input  logic [rotenc_pkg::CFG_W-1:0]   beep_ms,
    output logic                           buzzer_next
);

    logic                               beeping_reg;
    logic [rotenc_pkg::STAMP_W-1:0]     beep_start_reg;

    logic                               active;
    logic [rotenc_pkg::STAMP_W-1:0]     start;
    logic [rotenc_pkg::STAMP_W-1:0]     elapsed;

    // A fresh event restarts the timer within the same item
    assign active      = hit.hit | beeping_reg;
    assign start       = hit.hit ? hit.now_ms : beep_start_reg;
    assign elapsed     = hit.now_ms - start;
    assign buzzer_next = active & (elapsed < rotenc_pkg::STAMP_W'(beep_ms));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beeping_reg    <= 1'b0;
            beep_start_reg <= '0;
        end
        else if (step)
        begin
            beeping_reg    <= buzzer_next;
            beep_start_reg <= start;
        end
    end

endmodule

@@ src/rotary_encoder_event_qualifier_top.sv @@
// Top level of the rotary encoder event qualifier: input register, qualifier,
// beep timer and result register. Depends on rotenc_pkg, rotenc_if, rotenc_qualify, rotenc_beep.
//
//   channel   dir   beat contents
//   pins      in    clk_level, dir_level, switch_level, now_ms, take_event
//   report    out   event_code, event_waiting, buzzer_on
//   cfg_*     in    write enable, register index, 16-bit data
//
// One sample per clock sustained while the report side is not stalled; an accepted sample
// loads the input register, then the result register once it is free, raising report.valid.
// Reset: previous levels high, stamps zero, nothing pending, buzzer off,
// debounce_ms and beep_ms at 50.
// A stalled report holds its beat; pins.ready falls only while both registers are
// full and report.ready is low, so each such stalled cycle costs one input beat.
module rotary_encoder_event_qualifier_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    rotenc_sample_if.sink                       pins,
    rotenc_report_if.source                     report,
    input  logic                                cfg_we,
    input  logic [rotenc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rotenc_pkg::CFG_W-1:0]        cfg_data
);

    logic [rotenc_pkg::CFG_W-1:0]   debounce_reg;
    logic [rotenc_pkg::CFG_W-1:0]   beep_reg;

    logic                           in_vld_reg;
    rotenc_pkg::sample_t            smp_reg;
    logic                           out_vld_reg;
    rotenc_pkg::result_t            res_reg;

    logic                           adv;
    logic                           take_in;
    rotenc_pkg::hit_t               hit;
    rotenc_pkg::event_code_t        taken;
    logic                           waiting;
    logic                           buzzer_next;

    assign adv      = in_vld_reg & (~out_vld_reg | report.ready);
    assign take_in  = pins.valid & pins.ready;
    assign pins.ready = ~in_vld_reg | adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= rotenc_pkg::DEBOUNCE_RESET;
            beep_reg     <= rotenc_pkg::BEEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rotenc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_data;
                rotenc_pkg::CFG_BEEP:     beep_reg     <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (pins.ready)
        begin
            in_vld_reg <= pins.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            smp_reg.clk_level    <= pins.clk_level;
            smp_reg.dir_level    <= pins.dir_level;
            smp_reg.switch_level <= pins.switch_level;
            smp_reg.now_ms       <= pins.now_ms;
            smp_reg.take_event   <= pins.take_event;
        end
    end

    rotenc_qualify u_qualify
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .smp         (smp_reg),
        .debounce_ms (debounce_reg),
        .hit         (hit),
        .taken       (taken),
        .waiting     (waiting)
    );

    rotenc_beep u_beep
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (adv),
        .hit         (hit),
        .beep_ms     (beep_reg),
        .buzzer_next (buzzer_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (report.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.event_code    <= taken;
            res_reg.event_waiting <= waiting;
            res_reg.buzzer_on     <= buzzer_next;
        end
    end

    assign report.valid         = out_vld_reg;
    assign report.event_code    = res_reg.event_code;
    assign report.event_waiting = res_reg.event_waiting;
    assign report.buzzer_on     = res_reg.buzzer_on;

endmodule

@@ src/rotenc_checker.sv @@
// Port-level checks for the rotary encoder event qualifier, bound to the top level.
// Depends on rotenc_pkg and rotary_encoder_event_qualifier_top.
module rotenc_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pins_ready,
    input  logic       report_valid,
    input  logic       report_ready,
    input  logic [1:0] event_code,
    input  logic       event_waiting,
    input  logic       buzzer_on
);

    // Hold a stalled report beat
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=>
            report_valid && $stable(event_code) && $stable(event_waiting)
            && $stable(buzzer_on))
        else $error("stalled report beat changed");

    // With no result waiting the input side must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        !report_valid |-> pins_ready)
        else $error("pins stalled with empty result register");

    // Taking an event empties the pending slot
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && (event_code != rotenc_pkg::EV_NONE) |-> !event_waiting)
        else $error("event still waiting after a take");

    // While the output stays stalled, an input side that was closed must stay closed
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready && $past(report_valid && !report_ready)
            && $past(!pins_ready) |-> !pins_ready)
        else $error("pins reopened while output stalled and input full");

endmodule

bind rotary_encoder_event_qualifier_top rotenc_checker u_rotenc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .pins_ready    (pins.ready),
    .report_valid  (report.valid),
    .report_ready  (report.ready),
    .event_code    (report.event_code),
    .event_waiting (report.event_waiting),
    .buzzer_on     (report.buzzer_on)
);
